// File: sv/integer_alu_with_flags_and_conditions_macros.svh
// Assertion macros shared by the ALU checker.
`ifndef INTEGER_ALU_WITH_FLAGS_AND_CONDITIONS_MACROS_SVH
`define INTEGER_ALU_WITH_FLAGS_AND_CONDITIONS_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define IALU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define IALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ialu_pkg.sv
// Shared types and constants of the integer ALU with flags and conditions.
package ialu_pkg;

   typedef enum logic [2:0] {
      FUNC_ADD  = 3'd0,
      FUNC_OR   = 3'd1,
      FUNC_AND  = 3'd2,
      FUNC_SUB  = 3'd3,
      FUNC_XOR  = 3'd4,
      FUNC_CMP  = 3'd5,
      FUNC_TEST = 3'd6,
      FUNC_EVAL = 3'd7
   } func_type;

   localparam logic [11:0] FLAG_CF  = 12'h001;
   localparam logic [11:0] FLAG_PF  = 12'h004;
   localparam logic [11:0] FLAG_AF  = 12'h010;
   localparam logic [11:0] FLAG_ZF  = 12'h040;
   localparam logic [11:0] FLAG_SF  = 12'h080;
   localparam logic [11:0] FLAG_OF  = 12'h800;
   localparam logic [11:0] FLAG_ALL = FLAG_CF | FLAG_PF | FLAG_AF | FLAG_ZF | FLAG_SF | FLAG_OF;

   localparam logic [63:0] NARROW_MASK = 64'h0000_0000_ffff_ffff;

   typedef struct packed {
      func_type    func;
      logic [63:0] left_operand;
      logic [63:0] right_operand;
      logic        wide;
      logic [3:0]  cond_code;
   } req_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic [11:0] flags_out;
      logic        writes_back;
      logic        taken;
      logic        cond_known;
   } rsp_type;

   typedef struct packed {
      logic [11:0] flags;
      logic [11:0] known;
   } flag_state_type;

endpackage

// File: sv/ialu_cond.sv
// Jump condition evaluation against the current flag state.
module ialu_cond (
   input  logic [3:0]                cond_code,
   input  ialu_pkg::flag_state_type  state,
   output logic                      taken,
   output logic                      cond_known
);

   typedef enum logic [2:0] {
      TEST_O, TEST_C, TEST_Z, TEST_BE, TEST_S, TEST_P, TEST_L, TEST_LE
   } test_type;

   test_type    test;
   logic [11:0] need;
   logic        raw;
   logic        s_bit;
   logic        o_bit;

   assign test  = test_type'(cond_code[3:1]);
   assign s_bit = |(state.flags & ialu_pkg::FLAG_SF);
   assign o_bit = |(state.flags & ialu_pkg::FLAG_OF);

   always_comb begin
      unique case (test)
         TEST_O: begin
            need = ialu_pkg::FLAG_OF;
            raw  = o_bit;
         end
         TEST_C: begin
            need = ialu_pkg::FLAG_CF;
            raw  = |(state.flags & ialu_pkg::FLAG_CF);
         end
         TEST_Z: begin
            need = ialu_pkg::FLAG_ZF;
            raw  = |(state.flags & ialu_pkg::FLAG_ZF);
         end
         TEST_BE: begin
            need = ialu_pkg::FLAG_CF | ialu_pkg::FLAG_ZF;
            raw  = |(state.flags & (ialu_pkg::FLAG_CF | ialu_pkg::FLAG_ZF));
         end
         TEST_S: begin
            need = ialu_pkg::FLAG_SF;
            raw  = s_bit;
         end
         TEST_P: begin
            need = ialu_pkg::FLAG_PF;
            raw  = |(state.flags & ialu_pkg::FLAG_PF);
         end
         TEST_L: begin
            need = ialu_pkg::FLAG_SF | ialu_pkg::FLAG_OF;
            raw  = s_bit ^ o_bit;
         end
         default: begin
            need = ialu_pkg::FLAG_ZF | ialu_pkg::FLAG_SF | ialu_pkg::FLAG_OF;
            raw  = (|(state.flags & ialu_pkg::FLAG_ZF)) | (s_bit ^ o_bit);
         end
      endcase
   end

   // Low code bit negates; an unknown input flag forces not taken.
   assign cond_known = (state.known & need) == need;
   assign taken      = cond_known & (raw ^ cond_code[0]);

endmodule

// File: sv/ialu_exec.sv
// Single-pass ALU datapath: value, new flags, next flag state and result item.
module ialu_exec (
   input  ialu_pkg::req_type         item,
   input  ialu_pkg::flag_state_type  state,
   output ialu_pkg::rsp_type         result,
   output ialu_pkg::flag_state_type  state_next
);

   logic [63:0] mask;
   logic [63:0] a;
   logic [63:0] b;
   logic [64:0] sum;
   logic [64:0] diff;
   logic [63:0] v;
   logic [11:0] f;
   logic        is_add;
   logic        is_sub;
   logic        is_eval;
   logic        carry;
   logic        sa;
   logic        sb;
   logic        sv;
   logic        taken;
   logic        cond_known;

   ialu_cond u_cond (
      .cond_code  (item.cond_code),
      .state      (state),
      .taken      (taken),
      .cond_known (cond_known)
   );

   assign mask    = item.wide ? {64{1'b1}} : ialu_pkg::NARROW_MASK;
   assign a       = item.left_operand & mask;
   assign b       = item.right_operand & mask;
   assign is_add  = item.func == ialu_pkg::FUNC_ADD;
   assign is_sub  = (item.func == ialu_pkg::FUNC_SUB) || (item.func == ialu_pkg::FUNC_CMP);
   assign is_eval = item.func == ialu_pkg::FUNC_EVAL;

   assign sum  = {1'b0, a} + {1'b0, b};
   assign diff = {1'b0, a} - {1'b0, b};

   // Borrow shows in bit 64 at either width since operands are zero-extended.
   assign carry = is_sub ? diff[64] : (item.wide ? sum[64] : sum[32]);

   always_comb begin
      unique case (item.func)
         ialu_pkg::FUNC_ADD:                     v = sum[63:0] & mask;
         ialu_pkg::FUNC_SUB, ialu_pkg::FUNC_CMP: v = diff[63:0] & mask;
         ialu_pkg::FUNC_OR:                      v = a | b;
         ialu_pkg::FUNC_XOR:                     v = a ^ b;
         ialu_pkg::FUNC_AND, ialu_pkg::FUNC_TEST: v = a & b;
         default:                                v = '0;
      endcase
   end

   assign sa = item.wide ? a[63] : a[31];
   assign sb = item.wide ? b[63] : b[31];
   assign sv = item.wide ? v[63] : v[31];

   always_comb begin
      f = '0;
      if (is_add || is_sub) begin
         if (carry) f = f | ialu_pkg::FLAG_CF;
         if (a[4] ^ b[4] ^ v[4]) f = f | ialu_pkg::FLAG_AF;
         if (is_sub ? ((sa ^ sb) & (sa ^ sv)) : (~(sa ^ sb) & (sa ^ sv)))
            f = f | ialu_pkg::FLAG_OF;
      end
      if (v == '0) f = f | ialu_pkg::FLAG_ZF;
      if (sv) f = f | ialu_pkg::FLAG_SF;
      if (~^v[7:0]) f = f | ialu_pkg::FLAG_PF;
   end

   always_comb begin
      if (is_eval) begin
         state_next          = state;
         result.result_value = '0;
         result.flags_out    = state.flags;
         result.writes_back  = 1'b0;
         result.taken        = taken;
         result.cond_known   = cond_known;
      end else begin
         state_next.flags = (state.flags & ~ialu_pkg::FLAG_ALL) | f;
         // Logical ops leave AF cleared but not known.
         state_next.known = (is_add || is_sub) ? (state.known | ialu_pkg::FLAG_ALL)
                          : ((state.known | ialu_pkg::FLAG_ALL) & ~ialu_pkg::FLAG_AF);
         result.result_value = v;
         result.flags_out    = state_next.flags;
         result.writes_back  = (item.func != ialu_pkg::FUNC_CMP) &&
                               (item.func != ialu_pkg::FUNC_TEST);
         result.taken        = 1'b0;
         result.cond_known   = 1'b0;
      end
   end

endmodule

// File: sv/integer_alu_with_flags_and_conditions.sv
// Top level: x86-style integer ALU with status flags and jump conditions.
// Path: an accepted item is registered in the input stage, computed there by ialu_exec,
//    and captured in the result register that drives rsp_valid and rsp_payload.
// Throughput: one item per cycle while rsp_stall does not hold a full result register.
// Reset: both stages empty, all flags cleared and none marked known.
module integer_alu_with_flags_and_conditions (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ialu_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ialu_pkg::rsp_type rsp_payload
);

   // Input stage.
   logic                     req_valid_ff;
   logic                     req_valid_in;
   ialu_pkg::req_type        req_data_ff;

   // Result stage.
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   ialu_pkg::rsp_type        rsp_data_ff;

   // Architectural flag state.
   ialu_pkg::flag_state_type state_ff;
   ialu_pkg::flag_state_type state_in;

   ialu_pkg::rsp_type        exec_result;
   ialu_pkg::flag_state_type exec_state;
   logic                     take;
   logic                     advance;

   // Advance the input stage when the result register is empty or drains this cycle.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // Hold off a new transfer only when the input stage is full and stuck.
   assign req_stall = req_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   ialu_exec u_exec (
      .item       (req_data_ff),
      .state      (state_ff),
      .result     (exec_result),
      .state_next (exec_state)
   );

   always_comb begin
      // Refill on a transfer, drop when the item moves on, otherwise hold.
      if (take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      // Load on advance, keep while stalled, drop once taken.
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
      // Commit flags only when the item leaves the input stage, so the next
      // item always sees the state left by the one before it.
      state_in = advance ? exec_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers: capture on transfer or advance, no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         req_data_ff <= req_payload;
      end
      if (advance) begin
         rsp_data_ff <= exec_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// File: sv/ialu_checker.sv
// Port-level checker for the integer ALU, bound to the top level.
`include "integer_alu_with_flags_and_conditions_macros.svh"

module ialu_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ialu_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ialu_pkg::rsp_type rsp_payload
);

   logic unused_req;

   assign unused_req = req_valid ^ req_stall ^ (^req_payload);

   `IALU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed or dropped")
   `IALU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result offered right after reset")
   `IALU_ASSERT_SAME(a_taken_known, clock, reset, rsp_valid && rsp_payload.taken, rsp_payload.cond_known && !rsp_payload.writes_back && (rsp_payload.result_value == '0), "taken condition without known flags")
   `IALU_ASSERT_SAME(a_zf_match, clock, reset, rsp_valid && rsp_payload.writes_back, rsp_payload.flags_out[6] == (rsp_payload.result_value == '0), "ZF disagrees with result value")

endmodule

bind integer_alu_with_flags_and_conditions ialu_checker u_checker (.*);

// File: sim/tb_integer_alu_with_flags_and_conditions.sv
// Self-checking testbench for the x86-style integer ALU with status flags and jump conditions.
module tb_integer_alu_with_flags_and_conditions;

   // Jump condition tests, selected by the upper three bits of the condition code.
   // The low bit of the code inverts the test.
   typedef enum logic [2:0] {
      TEST_OVERFLOW = 3'd0,
      TEST_CARRY    = 3'd1,
      TEST_ZERO     = 3'd2,
      TEST_BELOW_EQ = 3'd3,
      TEST_SIGN     = 3'd4,
      TEST_PARITY   = 3'd5,
      TEST_LESS     = 3'd6,
      TEST_LESS_EQ  = 3'd7
   } cond_test_type;

   typedef struct {
      ialu_pkg::req_type op;
      bit                drain_first;   // hold the op back until every predicted result is out
   } pending_op_type;

   localparam int unsigned RANDOM_OPS   = 750;
   localparam int unsigned SETTLE_EDGES = 8;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   ialu_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   ialu_pkg::rsp_type rsp_payload;

   pending_op_type    pending_ops[$];
   ialu_pkg::rsp_type predicted_results[$];

   // Flag state as the block should hold it after every accepted transfer.
   ialu_pkg::flag_state_type alu_flags = '0;

   int unsigned mismatch_count = 0;
   int unsigned checked_count  = 0;
   int unsigned alu_count      = 0;
   int unsigned eval_count     = 0;
   int unsigned unknown_count  = 0;
   int unsigned drain_count    = 0;

   integer_alu_with_flags_and_conditions DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Flag prediction
   // -------------------------------------------------------------------------

   // Flags a condition test reads; the test is only meaningful once all are known.
   function automatic logic [11:0] flags_read_by(input cond_test_type t);
      case (t)
         TEST_OVERFLOW: return ialu_pkg::FLAG_OF;
         TEST_CARRY:    return ialu_pkg::FLAG_CF;
         TEST_ZERO:     return ialu_pkg::FLAG_ZF;
         TEST_BELOW_EQ: return ialu_pkg::FLAG_CF | ialu_pkg::FLAG_ZF;
         TEST_SIGN:     return ialu_pkg::FLAG_SF;
         TEST_PARITY:   return ialu_pkg::FLAG_PF;
         TEST_LESS:     return ialu_pkg::FLAG_SF | ialu_pkg::FLAG_OF;
         default:       return ialu_pkg::FLAG_ZF | ialu_pkg::FLAG_SF | ialu_pkg::FLAG_OF;
      endcase
   endfunction

   function automatic logic test_holds(input cond_test_type t, input logic [11:0] f);
      logic s_bit;
      logic o_bit;
      s_bit = (f & ialu_pkg::FLAG_SF) != 0;
      o_bit = (f & ialu_pkg::FLAG_OF) != 0;
      case (t)
         TEST_OVERFLOW: return o_bit;
         TEST_CARRY:    return (f & ialu_pkg::FLAG_CF) != 0;
         TEST_ZERO:     return (f & ialu_pkg::FLAG_ZF) != 0;
         TEST_BELOW_EQ: return (f & (ialu_pkg::FLAG_CF | ialu_pkg::FLAG_ZF)) != 0;
         TEST_SIGN:     return s_bit;
         TEST_PARITY:   return (f & ialu_pkg::FLAG_PF) != 0;
         TEST_LESS:     return s_bit != o_bit;
         default:       return ((f & ialu_pkg::FLAG_ZF) != 0) || (s_bit != o_bit);
      endcase
   endfunction

   // Work out the result of one accepted op, advance the flag state and queue the result.
   task automatic predict_alu_outcome(input ialu_pkg::req_type r);
      ialu_pkg::rsp_type want;
      cond_test_type     test;
      logic [11:0]       needed;
      logic [11:0]       new_flags;
      logic [63:0]       width_mask;
      logic [63:0]       sign_bit;
      logic [63:0]       a;
      logic [63:0]       b;
      logic [63:0]       v;
      logic              arith;
      want = '0;
      if (r.func == ialu_pkg::FUNC_EVAL) begin
         // Flag state is read only; nothing in it changes.
         test             = cond_test_type'(r.cond_code[3:1]);
         needed           = flags_read_by(test);
         want.flags_out   = alu_flags.flags;
         want.cond_known  = (alu_flags.known & needed) == needed;
         want.taken       = want.cond_known &&
                            (test_holds(test, alu_flags.flags) ^ r.cond_code[0]);
         eval_count++;
         if (!want.cond_known) unknown_count++;
      end else begin
         // Narrow ops drop the upper halves and take sign, carry and overflow at bit 31.
         width_mask = r.wide ? 64'hffff_ffff_ffff_ffff : ialu_pkg::NARROW_MASK;
         sign_bit   = r.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
         a          = r.left_operand & width_mask;
         b          = r.right_operand & width_mask;
         new_flags  = '0;
         arith      = 1'b1;
         case (r.func)
            ialu_pkg::FUNC_ADD: begin
               v = (a + b) & width_mask;
               if (v < a) new_flags |= ialu_pkg::FLAG_CF;
               if ((~(a ^ b) & (a ^ v) & sign_bit) != 0) new_flags |= ialu_pkg::FLAG_OF;
            end
            ialu_pkg::FUNC_SUB, ialu_pkg::FUNC_CMP: begin
               v = (a - b) & width_mask;
               if (a < b) new_flags |= ialu_pkg::FLAG_CF;
               if (((a ^ b) & (a ^ v) & sign_bit) != 0) new_flags |= ialu_pkg::FLAG_OF;
            end
            ialu_pkg::FUNC_OR: begin
               v     = a | b;
               arith = 1'b0;
            end
            ialu_pkg::FUNC_XOR: begin
               v     = a ^ b;
               arith = 1'b0;
            end
            default: begin
               v     = a & b;
               arith = 1'b0;
            end
         endcase
         if (arith && ((a ^ b ^ v) & 64'h10) != 0) new_flags |= ialu_pkg::FLAG_AF;
         if (v == 0) new_flags |= ialu_pkg::FLAG_ZF;
         if ((v & sign_bit) != 0) new_flags |= ialu_pkg::FLAG_SF;
         if (~^v[7:0]) new_flags |= ialu_pkg::FLAG_PF;
         // Logical ops leave AF clear but no longer known.
         alu_flags.known = arith ? (alu_flags.known | ialu_pkg::FLAG_ALL)
                                 : ((alu_flags.known | ialu_pkg::FLAG_ALL) & ~ialu_pkg::FLAG_AF);
         alu_flags.flags = (alu_flags.flags & ~ialu_pkg::FLAG_ALL) | new_flags;
         want.result_value = v;
         want.flags_out    = alu_flags.flags;
         want.writes_back  = !(r.func == ialu_pkg::FUNC_CMP || r.func == ialu_pkg::FUNC_TEST);
         alu_count++;
      end
      predicted_results.push_back(want);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   task automatic queue_op(input ialu_pkg::func_type f, input logic [63:0] a,
                           input logic [63:0] b, input logic w, input logic [3:0] code,
                           input bit drain);
      pending_op_type p;
      p.op.func          = f;
      p.op.left_operand  = a;
      p.op.right_operand = b;
      p.op.wide          = w;
      p.op.cond_code     = code;
      p.drain_first      = drain;
      pending_ops.push_back(p);
   endtask

   // Bias operands toward the corners that move carry, overflow, zero and sign.
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 64'h0;
         1: return 64'hffff_ffff_ffff_ffff;
         2: return 64'h7fff_ffff_ffff_ffff ^ 64'($urandom_range(0, 3));
         3: return 64'h8000_0000_0000_0000 | 64'($urandom_range(0, 3));
         4: return {$urandom, 32'h7fff_ffff ^ 32'($urandom_range(0, 3))};
         5: return {$urandom, 32'h8000_0000 | 32'($urandom_range(0, 3))};
         6: return 64'($urandom_range(0, 255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Mostly back to back, sometimes a few cycles, rarely a long hole.
   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_count++;
      $display("mismatch in %s at result %0d: got %h, want %h",
               what, checked_count, got, want);
   endtask

   // -------------------------------------------------------------------------
   // Request driver
   // -------------------------------------------------------------------------

   int unsigned req_idle_left = 0;
   int unsigned req_calm_left = 0;

   always @(posedge clock) begin
      logic           next_valid;
      pending_op_type p;
      next_valid = req_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // Predict each op at the edge that transfers it, then drop valid unless refilled.
         if (req_valid && !req_stall) begin
            predict_alu_outcome(req_payload);
            next_valid = 1'b0;
            if (req_calm_left > 0) begin
               req_calm_left--;
               req_idle_left = 0;
            end else if ($urandom_range(0, 39) == 0) begin
               req_calm_left = $urandom_range(20, 60);
               req_idle_left = 0;
            end else begin
               req_idle_left = gap_length();
            end
         end
         if (!next_valid) begin
            if (req_idle_left > 0) begin
               req_idle_left--;
            end else if (pending_ops.size() > 0) begin
               // Hold a drain-marked op until the result side has emptied out.
               if (!pending_ops[0].drain_first || predicted_results.size() == 0) begin
                  p = pending_ops.pop_front();
                  if (p.drain_first) drain_count++;
                  req_payload <= p.op;
                  next_valid = 1'b1;
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor and stall generator
   // -------------------------------------------------------------------------

   int unsigned rsp_hold_left = 0;
   int unsigned rsp_calm_left = 0;

   always @(posedge clock) begin
      ialu_pkg::rsp_type got;
      ialu_pkg::rsp_type want;
      logic              next_stall;
      next_stall = 1'b0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (predicted_results.size() == 0) begin
               note_mismatch("unexpected transfer", got.result_value, 64'h0);
            end else begin
               want = predicted_results.pop_front();
               if (got.result_value !== want.result_value)
                  note_mismatch("result_value", got.result_value, want.result_value);
               if (got.flags_out !== want.flags_out)
                  note_mismatch("flags_out", 64'(got.flags_out), 64'(want.flags_out));
               if (got.writes_back !== want.writes_back)
                  note_mismatch("writes_back", 64'(got.writes_back), 64'(want.writes_back));
               if (got.taken !== want.taken)
                  note_mismatch("taken", 64'(got.taken), 64'(want.taken));
               if (got.cond_known !== want.cond_known)
                  note_mismatch("cond_known", 64'(got.cond_known), 64'(want.cond_known));
               checked_count++;
            end
         end
         // Advance the stall pattern: calm stretches, then random stall runs.
         if (rsp_calm_left > 0) begin
            rsp_calm_left--;
         end else if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            next_stall = 1'b1;
         end else if ($urandom_range(0, 49) == 0) begin
            rsp_calm_left = $urandom_range(20, 60);
         end else begin
            rsp_hold_left = gap_length();
            if (rsp_hold_left > 0) begin
               rsp_hold_left--;
               next_stall = 1'b1;
            end
         end
         rsp_stall <= next_stall;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // -------------------------------------------------------------------------

   initial begin
      logic [63:0] a;
      logic [63:0] b;
      int unsigned settle;

      // Conditions before any ALU op: no flag is known yet.
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1,
               4'd15, 1'b0);
      // Add corners: wrap to zero with carry, signed overflow, narrow overflow
      // with junk in the upper halves.
      queue_op(ialu_pkg::FUNC_ADD, 64'hffff_ffff_ffff_ffff, 64'h1, 1'b1, 4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd2, 1'b0);
      queue_op(ialu_pkg::FUNC_ADD, 64'h7fff_ffff_ffff_ffff, 64'h1, 1'b1, 4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_ADD, 64'hdead_beef_7fff_ffff, 64'hffff_0000_0000_0001, 1'b0,
               4'd0, 1'b0);
      // Sub and cmp: narrow borrow, wide overflow, equal values.
      queue_op(ialu_pkg::FUNC_SUB, 64'hffff_ffff_0000_0000, 64'h1, 1'b0, 4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd3, 1'b0);
      queue_op(ialu_pkg::FUNC_SUB, 64'h8000_0000_0000_0000, 64'h1, 1'b1, 4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd12, 1'b0);
      queue_op(ialu_pkg::FUNC_CMP, 64'h1234_5678_9abc_def0, 64'h1234_5678_9abc_def0, 1'b1,
               4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd7, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd10, 1'b0);
      // Logical ops: AF drops out of the known set but no condition reads it.
      queue_op(ialu_pkg::FUNC_OR, 64'h0, 64'h0, 1'b1, 4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd14, 1'b0);
      queue_op(ialu_pkg::FUNC_AND, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1,
               4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd9, 1'b0);
      queue_op(ialu_pkg::FUNC_XOR, 64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa, 1'b0,
               4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_TEST, 64'hffff_ffff_8000_0001, 64'h0000_0001_8000_0000, 1'b0,
               4'd0, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd8, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd11, 1'b0);
      queue_op(ialu_pkg::FUNC_EVAL, 64'h0, 64'h0, 1'b0, 4'd13, 1'b0);

      // Random ops; a few of them wait for the pipe to drain first.
      for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
         a = pick_operand();
         b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
         queue_op(ialu_pkg::func_type'($urandom_range(0, 7)), a, b, 1'($urandom_range(0, 1)),
                  4'($urandom_range(0, 15)), (i == 300) || ($urandom_range(0, 99) == 0));
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for every op to transfer and every predicted result to come back.
      while (pending_ops.size() != 0 || req_valid || predicted_results.size() != 0)
         @(posedge clock);
      // Let a few more edges pass so any stray result is caught.
      for (settle = 0; settle < SETTLE_EDGES; settle++) @(posedge clock);

      $display("ran %0d ALU ops and %0d condition checks (%0d with flags unknown)",
               alu_count, eval_count, unknown_count);
      $display("checked %0d results with %0d drain pauses; %0d mismatches",
               checked_count, drain_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[integer_alu_with_flags_and_conditions] OK");
      end else begin
         $display("[integer_alu_with_flags_and_conditions] ERROR");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #2_000_000;
      $display("timeout with %0d results still expected", predicted_results.size());
      $display("[integer_alu_with_flags_and_conditions] ERROR");
      $finish;
   end

endmodule
